// File: hdl/xy_segment_planner_defines.svh
// assertion macros shared by the planner rtl
`ifndef XY_SEGMENT_PLANNER_DEFINES_SVH
`define XY_SEGMENT_PLANNER_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define XYSP_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define XYSP_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/xysp_pkg.sv
// types and codes shared by the planner rtl
`default_nettype none

package xysp_pkg;

    localparam int IDX_W = 16;

    typedef enum logic
    {
        CMD_PLAN   = 1'b0,
        CMD_FINISH = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        WASH_NONE = 2'd0,
        WASH_OFF  = 2'd1,
        WASH_ON   = 2'd2
    } washer_t;

    // report fields that ride alongside the move through the pipeline
    typedef struct packed
    {
        washer_t            washer_action;
        logic               progress_valid;
        logic [IDX_W-1:0]   progress_done;
        logic [IDX_W-1:0]   progress_total;
        logic               job_complete;
    } report_t;

endpackage

`default_nettype wire

// File: hdl/xysp_isqrt.sv
// pipelined floor square root, one root bit per stage, with a tag carried along
`default_nettype none

module xysp_isqrt
#(
    parameter int ROOT_W = 25,
    parameter int TAG_W  = 86
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_vld,
    input  wire logic [2*ROOT_W-1:0]    radicand,
    input  wire logic [TAG_W-1:0]       in_tag,
    output logic                        out_vld,
    output logic [ROOT_W-1:0]           root,
    output logic [TAG_W-1:0]            out_tag
);

    localparam int RW    = ROOT_W + 2;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int LAST  = ROOT_W - 1;

    // stage inputs: index 0 is the module input, index k is stage k-1's registers
    logic [RW-1:0]      rem_in  [ROOT_W];
    logic [ROOT_W-1:0]  root_in [ROOT_W];
    logic [RAD_W-1:0]   rad_in  [ROOT_W];
    logic [TAG_W-1:0]   tag_in  [ROOT_W];
    logic [ROOT_W-1:0]  vld_in;

    // stage registers
    logic [RW-1:0]      rem_reg  [LAST];
    logic [RAD_W-1:0]   rad_reg  [LAST];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    logic [TAG_W-1:0]   tag_reg  [ROOT_W];
    logic               vld_reg  [ROOT_W];

    assign rem_in[0]  = '0;
    assign root_in[0] = '0;
    assign rad_in[0]  = radicand;
    assign tag_in[0]  = in_tag;
    assign vld_in[0]  = in_vld;

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic [RW-1:0]      rem_sh;
            logic [RW-1:0]      trial;
            logic               fits;
            logic [ROOT_W-1:0]  root_next;

            // bring down the next two radicand bits and try the next root bit
            assign rem_sh    = {rem_in[k][RW-3:0], rad_in[k][2*(LAST-k) +: 2]};
            assign trial     = {root_in[k], 2'b01};
            assign fits      = (rem_sh >= trial);
            assign root_next = {root_in[k][ROOT_W-2:0], fits};

            if (k > 0)
            begin : g_link
                assign vld_in[k]  = vld_reg[k-1];
                assign root_in[k] = root_reg[k-1];
                assign tag_in[k]  = tag_reg[k-1];
                assign rem_in[k]  = rem_reg[k-1];
                assign rad_in[k]  = rad_reg[k-1];
            end

            // valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end

            // root and tag
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[k] <= root_next;
                    tag_reg[k]  <= tag_in[k];
                end
            end

            // remainder and radicand go on only to stages that still need them
            if (k < LAST)
            begin : g_carry
                logic [RW-1:0] rem_next;

                assign rem_next = fits ? (rem_sh - trial) : rem_sh;

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k] <= rem_next;
                        rad_reg[k] <= rad_in[k];
                    end
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[LAST];
    assign root    = root_reg[LAST];
    assign out_tag = tag_reg[LAST];

endmodule

`default_nettype wire

// File: hdl/xy_segment_planner.sv
// two-axis move planner: step distances, directions, tick count and washer reports
//
//  channel   handshake               payload
//  cmd       cmd_valid / cmd_stall   command, target_x/y, position_x/y, point_index, tool_index
//  plan      plan_valid / plan_stall x/y_steps, x/y_clockwise, ticks, move_valid, washer, progress
//  cfg       cfg_wr_en               cfg_wr_data -> tool_count
//
//  one item per cycle unless plan_stall holds a finished item at the output; the stages are
//  one distance stage, one squaring stage, one sum stage and one stage per root bit.
//  the last root stage is the output register; the whole pipe advances together.
//  cmd_stall is high only while a finished item waits at the output under plan_stall.
//  reset clears valid bits and tool_count; payload registers are not reset.
`default_nettype none

`include "xy_segment_planner_defines.svh"

module xy_segment_planner
    import xysp_pkg::*;
#(
    parameter int POS_BITS = 24
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_wr_en,
    input  wire logic [IDX_W-1:0]       cfg_wr_data,

    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire logic                   command,
    input  wire logic [POS_BITS-1:0]    target_x,
    input  wire logic [POS_BITS-1:0]    target_y,
    input  wire logic [POS_BITS-1:0]    position_x,
    input  wire logic [POS_BITS-1:0]    position_y,
    input  wire logic [IDX_W-1:0]       point_index,
    input  wire logic [IDX_W-1:0]       tool_index,

    output logic                        plan_valid,
    input  wire logic                   plan_stall,
    output logic [POS_BITS-1:0]         x_steps,
    output logic [POS_BITS-1:0]         y_steps,
    output logic                        x_clockwise,
    output logic                        y_clockwise,
    output logic [POS_BITS:0]           ticks,
    output logic                        move_valid,
    output logic [1:0]                  washer_action,
    output logic                        progress_valid,
    output logic [IDX_W-1:0]            progress_done,
    output logic [IDX_W-1:0]            progress_total,
    output logic                        job_complete
);

    localparam int ROOT_W = POS_BITS + 1;
    localparam int SQ_W   = 2 * POS_BITS;
    localparam int REP_W  = $bits(report_t);
    localparam int TAG_W  = 2 * POS_BITS + 2 + REP_W;

    logic                   adv;
    logic [IDX_W-1:0]       tool_count_reg;

    // stage 1 next values
    logic                   is_finish;
    logic                   x_gt;
    logic                   y_gt;
    logic [POS_BITS-1:0]    x_dist;
    logic [POS_BITS-1:0]    y_dist;
    logic [POS_BITS-1:0]    s1_xs_next;
    logic [POS_BITS-1:0]    s1_ys_next;
    logic                   s1_xcw_next;
    logic                   s1_ycw_next;
    report_t                s1_rep_next;

    // stage registers
    logic                   s1_vld_reg;
    logic [POS_BITS-1:0]    s1_xs_reg;
    logic [POS_BITS-1:0]    s1_ys_reg;
    logic                   s1_xcw_reg;
    logic                   s1_ycw_reg;
    report_t                s1_rep_reg;

    logic                   s2_vld_reg;
    logic [SQ_W-1:0]        s2_xsq_reg;
    logic [SQ_W-1:0]        s2_ysq_reg;
    logic [POS_BITS-1:0]    s2_xs_reg;
    logic [POS_BITS-1:0]    s2_ys_reg;
    logic                   s2_xcw_reg;
    logic                   s2_ycw_reg;
    report_t                s2_rep_reg;

    logic                   s3_vld_reg;
    logic [SQ_W:0]          s3_sum_reg;
    logic [TAG_W-1:0]       s3_tag_reg;

    logic [SQ_W-1:0]        s2_xsq_next;
    logic [SQ_W-1:0]        s2_ysq_next;
    logic [SQ_W:0]          s3_sum_next;

    logic [TAG_W-1:0]       out_tag;
    report_t                out_rep;

    // the pipe moves unless a result sits at the output under stall
    assign adv       = !plan_valid || !plan_stall;
    assign cmd_stall = !adv;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tool_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            tool_count_reg <= cfg_wr_data;
        end
    end

    // stage 1: axis distances, directions and report
    assign is_finish = (command == CMD_FINISH);
    assign x_gt      = ($signed(target_x) > $signed(position_x));
    assign y_gt      = ($signed(target_y) > $signed(position_y));
    assign x_dist    = x_gt ? (target_x - position_x) : (position_x - target_x);
    assign y_dist    = y_gt ? (target_y - position_y) : (position_y - target_y);

    always_comb
    begin
        s1_xs_next  = x_dist;
        s1_ys_next  = y_dist;
        s1_xcw_next = !x_gt;
        s1_ycw_next = y_gt;
        s1_rep_next = '{washer_action: WASH_NONE, progress_valid: 1'b0,
                        progress_done: '0, progress_total: '0, job_complete: 1'b0};
        if (is_finish)
        begin
            s1_xs_next  = '0;
            s1_ys_next  = '0;
            s1_xcw_next = 1'b0;
            s1_ycw_next = 1'b0;
            s1_rep_next = '{washer_action: WASH_OFF, progress_valid: 1'b1,
                            progress_done: tool_count_reg,
                            progress_total: tool_count_reg, job_complete: 1'b1};
        end
        else if (point_index == '0 && tool_index != '0)
        begin
            // first point of a later tool path: washer off and report
            s1_rep_next = '{washer_action: WASH_OFF, progress_valid: 1'b1,
                            progress_done: tool_index,
                            progress_total: tool_count_reg, job_complete: 1'b0};
        end
        else if (point_index == IDX_W'(1))
        begin
            s1_rep_next.washer_action = WASH_ON;
        end
    end

    // stage 2: squares
    assign s2_xsq_next = SQ_W'(s1_xs_reg) * SQ_W'(s1_xs_reg);
    assign s2_ysq_next = SQ_W'(s1_ys_reg) * SQ_W'(s1_ys_reg);

    // stage 3: sum of squares
    assign s3_sum_next = {1'b0, s2_xsq_reg} + {1'b0, s2_ysq_reg};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= cmd_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xs_reg  <= s1_xs_next;
            s1_ys_reg  <= s1_ys_next;
            s1_xcw_reg <= s1_xcw_next;
            s1_ycw_reg <= s1_ycw_next;
            s1_rep_reg <= s1_rep_next;

            s2_xsq_reg <= s2_xsq_next;
            s2_ysq_reg <= s2_ysq_next;
            s2_xs_reg  <= s1_xs_reg;
            s2_ys_reg  <= s1_ys_reg;
            s2_xcw_reg <= s1_xcw_reg;
            s2_ycw_reg <= s1_ycw_reg;
            s2_rep_reg <= s1_rep_reg;

            s3_sum_reg <= s3_sum_next;
            s3_tag_reg <= {s2_xs_reg, s2_ys_reg, s2_xcw_reg, s2_ycw_reg, s2_rep_reg};
        end
    end

    // root stages, last one is the output register
    xysp_isqrt
    #(
        .ROOT_W (ROOT_W),
        .TAG_W  (TAG_W)
    )
    u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s3_vld_reg),
        .radicand ({1'b0, s3_sum_reg}),
        .in_tag   (s3_tag_reg),
        .out_vld  (plan_valid),
        .root     (ticks),
        .out_tag  (out_tag)
    );

    // unpack the item at the output
    assign x_steps        = out_tag[TAG_W-1 -: POS_BITS];
    assign y_steps        = out_tag[TAG_W-1-POS_BITS -: POS_BITS];
    assign x_clockwise    = out_tag[REP_W+1];
    assign y_clockwise    = out_tag[REP_W];
    assign out_rep        = report_t'(out_tag[REP_W-1:0]);
    assign move_valid     = |ticks;
    assign washer_action  = out_rep.washer_action;
    assign progress_valid = out_rep.progress_valid;
    assign progress_done  = out_rep.progress_done;
    assign progress_total = out_rep.progress_total;
    assign job_complete   = out_rep.job_complete;

    // checks
    `XYSP_CHECK(a_stall_only_when_blocked, cmd_stall, plan_valid && plan_stall,
        "input stalled without a blocked output")
    `XYSP_CHECK_NEXT(a_accept_enters_pipe, cmd_valid && !cmd_stall, s1_vld_reg,
        "accepted item missing from first stage")
    `XYSP_CHECK(a_finish_no_move, plan_valid && job_complete,
        ticks == '0 && x_steps == '0 && y_steps == '0 && !x_clockwise && !y_clockwise,
        "finish item carries a move")
    `XYSP_CHECK(a_no_report_zero, plan_valid && !progress_valid,
        progress_done == '0 && progress_total == '0, "report counts without a report")
    `XYSP_CHECK(a_ticks_bound, plan_valid,
        ticks >= ROOT_W'(x_steps) && ticks >= ROOT_W'(y_steps),
        "tick count below an axis distance")

endmodule

`default_nettype wire
